@@ hdl/gmfb_pkg.sv @@
// gmfb_pkg: shared constants, types and mode tables of the graphics mode frame store
`timescale 1ns / 1ps
`default_nettype none
package gmfb_pkg;

    localparam int ROW_STRIDE = 320;
    localparam int ROW_COUNT  = 200;
    localparam int STORE_SIZE = ROW_STRIDE * ROW_COUNT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);

    typedef logic [ADDR_W-1:0] addr_t;

    // command kinds carried in s_tuser
    localparam logic [2:0] KIND_GRAPHICS = 3'd0;
    localparam logic [2:0] KIND_LOCATE   = 3'd1;
    localparam logic [2:0] KIND_PLOT     = 3'd2;

    // mode byte fields
    localparam int MODE_W       = 4;
    localparam int NO_CLEAR_BIT = 5;

    // operations of the shared adder
    typedef enum logic [1:0] {
        ADD_ROW,    // row * 320 as (row << 8) + (row << 6)
        ADD_COL,    // acc + column
        ADD_INC     // acc + 1 for the clearing sweep
    } add_op_t;

    typedef struct packed {
        add_op_t     op;
        addr_t       acc;
        logic [7:0]  row;
        logic [15:0] col;
    } add_req_t;

    typedef struct packed {
        logic       we;
        addr_t      addr;
        logic [7:0] wdata;
    } store_req_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROW,
        ST_COL,
        ST_ACCESS,
        ST_READ,
        ST_RESP
    } state_t;

    function automatic logic [8:0] mode_width(input logic [MODE_W-1:0] m);
        logic [8:0] w;
        unique case (m)
            4'd0, 4'd3, 4'd12, 4'd13:        w = 9'd40;
            4'd1, 4'd2:                      w = 9'd20;
            4'd4, 4'd5, 4'd9, 4'd10, 4'd11:  w = 9'd80;
            4'd6, 4'd7, 4'd14, 4'd15:        w = 9'd160;
            4'd8:                            w = 9'd320;
            default:                         w = 9'd40;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] mode_height(input logic [MODE_W-1:0] m);
        logic [7:0] h;
        unique case (m)
            4'd0, 4'd1, 4'd3, 4'd12:                         h = 8'd24;
            4'd2, 4'd13:                                     h = 8'd12;
            4'd4, 4'd5:                                      h = 8'd48;
            4'd6, 4'd7:                                      h = 8'd96;
            4'd8, 4'd9, 4'd10, 4'd11, 4'd14, 4'd15:          h = 8'd192;
            default:                                         h = 8'd24;
        endcase
        return h;
    endfunction

    // colour count minus one
    function automatic logic [7:0] mode_mask(input logic [MODE_W-1:0] m);
        logic [7:0] k;
        unique case (m)
            4'd0, 4'd1, 4'd2, 4'd12, 4'd13:  k = 8'hFF;
            4'd3, 4'd5, 4'd7, 4'd15:         k = 8'h03;
            4'd4, 4'd6, 4'd8, 4'd14:         k = 8'h01;
            4'd9, 4'd10, 4'd11:              k = 8'h0F;
            default:                         k = 8'hFF;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

@@ hdl/graphics_mode_framebuffer_core.sv @@
// graphics_mode_framebuffer_core: top level of the graphics mode frame store
//
// usage
//   slave side: s_tuser carries the command kind, s_tdata the cursor and data;
//   one transfer is one command. master side: one result transfer per command.
//   commands: graphics (mode change, clears the store unless data bit 5 is set),
//   locate (read back a pixel), plot (write a masked colour), drawto and fillto
//   (bounds status only).
// sequencing
//   a sequencer steps one shared adder through the address (row part, then
//   column part), then does one memory access; locate then takes the pixel
//   from the registered read data of the store.
//   a clearing mode change walks the 64000-byte store one byte a cycle through
//   the same adder. s_tready is low while a command runs.
// reset
//   mode 0 is selected and a clearing pass zeroes the store;
//   s_tready stays low until it ends.
// stall
//   the result sits in an output register; a new command can be taken while
//   it waits, but the next result waits until m_tready takes the old one.
`timescale 1ns / 1ps
`default_nettype none
module graphics_mode_framebuffer_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // x[15:0], y[23:16], data[39:24]
    input  wire  [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // pixel[7:0], status[8], zero[15:9]
    output logic        m_tuser    // pixel_valid[0]
);
    import gmfb_pkg::*;

    state_t            state_reg, state_next;
    addr_t             acc_reg, acc_next;
    logic              clr_resp_reg, clr_resp_next;
    logic [MODE_W-1:0] mode_reg, mode_next;

    // latched command
    logic [2:0]        kind_reg, kind_next;
    logic [15:0]       x_reg, x_next;
    logic [7:0]        y_reg, y_next;
    logic [15:0]       data_reg, data_next;

    // pending result
    logic [7:0]        res_pixel_reg, res_pixel_next;
    logic              res_valid_reg, res_valid_next;
    logic              res_status_reg, res_status_next;

    // output register
    logic              m_tvalid_reg, m_tvalid_next;
    logic [7:0]        out_pixel_reg, out_pixel_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_status_reg, out_status_next;

    add_req_t          add_req;
    addr_t             add_sum;
    store_req_t        store_req;
    logic [7:0]        store_rdata;
    logic              in_bounds;
    logic              accept;

    gmfb_adder u_adder (
        .req (add_req),
        .sum (add_sum)
    );

    gmfb_store u_store (
        .clk   (clk),
        .req   (store_req),
        .rdata (store_rdata)
    );

    // bounds test against the active size of the current mode
    assign in_bounds = (x_reg < {7'b0, mode_width(mode_reg)}) && (y_reg < mode_height(mode_reg));

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            acc_reg      <= '0;
            clr_resp_reg <= 1'b0;
            mode_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            acc_reg      <= acc_next;
            clr_resp_reg <= clr_resp_next;
            mode_reg     <= mode_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        data_reg       <= data_next;
        res_pixel_reg  <= res_pixel_next;
        res_valid_reg  <= res_valid_next;
        res_status_reg <= res_status_next;
        out_pixel_reg  <= out_pixel_next;
        out_valid_reg  <= out_valid_next;
        out_status_reg <= out_status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        acc_next        = acc_reg;
        clr_resp_next   = clr_resp_reg;
        mode_next       = mode_reg;
        kind_next       = kind_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        data_next       = data_reg;
        res_pixel_next  = res_pixel_reg;
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        out_pixel_next  = out_pixel_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;

        add_req.op      = ADD_INC;
        add_req.acc     = acc_reg;
        add_req.row     = y_reg;
        add_req.col     = x_reg;

        store_req.we    = 1'b0;
        store_req.addr  = acc_reg;
        store_req.wdata = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // one byte a cycle, address stepped by the shared adder
                store_req.we = 1'b1;
                add_req.op   = ADD_INC;
                acc_next     = add_sum;
                if (acc_reg == addr_t'(STORE_SIZE - 1))
                begin
                    acc_next      = '0;
                    clr_resp_next = 1'b0;
                    state_next    = clr_resp_reg ? ST_RESP : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next       = s_tuser;
                    x_next          = s_tdata[15:0];
                    y_next          = s_tdata[23:16];
                    data_next       = s_tdata[39:24];
                    res_pixel_next  = '0;
                    res_valid_next  = 1'b0;
                    res_status_next = 1'b0;
                    if (s_tuser == KIND_GRAPHICS)
                    begin
                        mode_next = s_tdata[24 +: MODE_W];
                        if (!s_tdata[24 + NO_CLEAR_BIT])
                        begin
                            acc_next      = '0;
                            clr_resp_next = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        else
                        begin
                            state_next = ST_RESP;
                        end
                    end
                    else
                    begin
                        state_next = ST_ROW;
                    end
                end
            end
            ST_ROW:
            begin
                add_req.op = ADD_ROW;
                acc_next   = add_sum;
                state_next = ST_COL;
            end
            ST_COL:
            begin
                add_req.op = ADD_COL;
                acc_next   = add_sum;
                state_next = ST_ACCESS;
            end
            ST_ACCESS:
            begin
                res_status_next = !in_bounds;
                store_req.wdata = data_reg[7:0] & mode_mask(mode_reg);
                store_req.we    = in_bounds && (kind_reg == KIND_PLOT);
                if (in_bounds && (kind_reg == KIND_LOCATE))
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_READ:
            begin
                res_pixel_next = store_rdata;
                res_valid_next = 1'b1;
                state_next     = ST_RESP;
            end
            ST_RESP:
            begin
                // load the output register once the previous result is gone
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next   = 1'b1;
                    out_pixel_next  = res_pixel_reg;
                    out_valid_next  = res_valid_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, out_status_reg, out_pixel_reg};
    assign m_tuser  = out_valid_reg;

`ifndef SYNTHESIS
    // the clearing sweep only ever writes zeros
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (store_req.we && store_req.wdata == 8'd0))
        else $error("clearing sweep wrote a nonzero byte");

    // every write stays inside the store
    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        store_req.we |-> (store_req.addr < addr_t'(STORE_SIZE)))
        else $error("store write address out of range");

    // a valid pixel is only reported for an in-bounds cursor
    a_valid_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> !m_tdata[8])
        else $error("pixel_valid with out-of-range status");

    // only one command in flight
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("ready stayed high after a transfer");
`endif

endmodule
`default_nettype wire

@@ hdl/gmfb_adder.sv @@
// gmfb_adder: shared address adder used by the sequencer for every address step
`timescale 1ns / 1ps
`default_nettype none
module gmfb_adder (
    input  wire gmfb_pkg::add_req_t req,
    output gmfb_pkg::addr_t         sum
);
    import gmfb_pkg::*;

    addr_t opa;
    addr_t opb;

    always_comb
    begin
        case (req.op)
            ADD_ROW:
            begin
                // stride 320 = 256 + 64
                opa = addr_t'({req.row, 8'b0});
                opb = addr_t'({req.row, 6'b0});
            end
            ADD_COL:
            begin
                opa = req.acc;
                opb = req.col[ADDR_W-1:0];
            end
            default:
            begin
                opa = req.acc;
                opb = addr_t'(1);
            end
        endcase
    end

    assign sum = opa + opb;

endmodule
`default_nettype wire

@@ hdl/gmfb_store.sv @@
// gmfb_store: single-port pixel memory with registered read data
`timescale 1ns / 1ps
`default_nettype none
module gmfb_store (
    input  wire                       clk,
    input  wire gmfb_pkg::store_req_t req,
    output logic [7:0]                rdata
);
    import gmfb_pkg::*;

    logic [7:0] mem [0:STORE_SIZE-1];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire
